### rtl/ma10_pkg.sv
// Shared definitions for the moving average block: field widths, the default
// window length and the status record of the iterative divider.
// No dependencies.
`timescale 1ns / 1ps

package ma10_pkg;

  // Width of one ADC sample and of one averaged result in tenths.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned AVG_W    = 16;

  // Default number of samples in the averaging window.
  localparam int unsigned WINDOW_DEF = 20;

  // Status reported by the divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/ma10_if.sv
// Valid/ready channel interfaces for the sample input and the averaged output.
// Depends on ma10_pkg for the payload widths.
`timescale 1ns / 1ps

interface ma10_sample_if;
  import ma10_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ma10_avg_if;
  import ma10_pkg::*;

  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average_tenths;

  modport source (output valid, output average_tenths, input ready);
  modport sink (input valid, input average_tenths, output ready);
endinterface

### rtl/moving_average_x10.sv
// Top level of the moving average block: averages the last WINDOW samples
// in tenths. Depends on ma10_pkg, ma10_if, ma10_ram and ma10_div.
`timescale 1ns / 1ps

// Channel  Role    Handshake    Payload
// in_i     sink    valid/ready  sample, 12 bits unsigned
// out_o    source  valid/ready  average_tenths, 16 bits unsigned
//
// Each request takes WINDOW-dependent time: the oldest slot is read in the
// accepting cycle, then the running sum and ring are updated, then the
// divider is loaded and works out one bit per dividend bit (21 for a
// window of 20), so the one-bit-a-step divider sets the time from
// acceptance to result.
// A new sample is taken once the result has moved into the output register,
// even while that result still waits to be taken downstream.
// Reset clears the count, the write pointer and the running sum at once; the
// sample ring needs no clearing, as a slot is only used once it has been
// written. A stalled output holds the finished quotient in the divider.

module moving_average_x10 #(
  parameter int unsigned WINDOW = ma10_pkg::WINDOW_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ma10_sample_if.sink  in_i,
  ma10_avg_if.source   out_o
);
  import ma10_pkg::*;

  // Ring addressing, sample count and sum widths all follow the window.
  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  // Ten times the sum needs four more bits.
  localparam int unsigned DVD_W = SUM_W + 4;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_START = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [PTR_W-1:0]    wp_q, wp_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic                out_valid_q, out_valid_d;
  logic [AVG_W-1:0]    avg_q;

  logic                in_fire;
  logic                full;
  logic                ram_we;
  logic [SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]    drop;
  logic                div_start;
  logic [DVD_W-1:0]    dividend;
  div_status_t         div_st;
  logic [DVD_W-1:0]    quotient;
  logic                out_free;
  logic                out_load;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign full     = (cnt_q == CNT_W'(WINDOW));
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == S_DIV) && div_st.done && out_free;

  // The oldest sample is read in the accepting cycle, so its value is back
  // in the following cycle when the ring slot is overwritten. Each request
  // finishes its write before the next one can read, so no forwarding is
  // needed.
  ma10_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .re_i    (in_fire),
    .raddr_i (wp_q),
    .rdata_o (oldest)
  );

  assign ram_we = (state_q == S_READ);
  // Once the window is full the slot under the pointer holds the oldest
  // sample, which leaves the sum as the new one enters.
  assign drop   = full ? SUM_W'(oldest) : '0;

  // Multiply by ten as eight times plus two times.
  assign dividend  = DVD_W'({sum_q, 3'b000}) + DVD_W'({sum_q, 1'b0});
  assign div_start = (state_q == S_START);

  ma10_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .status_o   (div_st),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        sum_d = sum_q - drop + SUM_W'(sample_q);
        if (!full) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (wp_q == PTR_W'(WINDOW - 1)) begin
          wp_d = '0;
        end else begin
          wp_d = wp_q + 1'b1;
        end
        state_d = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register parts the divider from the downstream side.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_i.sample;
    end
    if (out_load) begin
      avg_q <= quotient[AVG_W-1:0];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.average_tenths = avg_q;

`ifndef SYNTH
  // The count never exceeds the window and the pointer stays on the ring.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(WINDOW)) && (32'(wp_q) < WINDOW))
    else $error("sample count or write pointer out of range");

  // The running sum can never exceed the largest possible held samples.
  a_sum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(sum_q) <= 32'(cnt_q) * ((32'd1 << SAMPLE_W) - 32'd1)))
    else $error("running sum exceeds count times full scale");

  // No sample is taken while the divider works on the previous one.
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !div_st.busy)
    else $error("sample accepted during a division");

  // Every accepted sample is followed by a ring write in the next cycle.
  a_write_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ram_we)
    else $error("ring write missing after sample acceptance");
`endif

endmodule

### rtl/ma10_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module ma10_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 20,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ma10_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ma10_pkg for the status record.
`timescale 1ns / 1ps

module ma10_div #(
  parameter int unsigned DVD_W = 21,
  parameter int unsigned DVS_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVD_W-1:0]     dividend_i,
  input  logic [DVS_W-1:0]     divisor_i,
  output ma10_pkg::div_status_t status_o,
  output logic [DVD_W-1:0]     quotient_o
);
  import ma10_pkg::*;

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           fits;

  // The dividend register shifts out at the top and collects quotient bits
  // at the bottom, so after DVD_W steps it holds the quotient.
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    fits   = ~diff[DVS_W];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = STEP_W'(DVD_W);
    end else if (busy_q) begin
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q;

endmodule

### test/moving_average_x10_checker.sv
// Scoreboard for the moving average block: watches both channels, predicts
// each average in tenths and compares it with the result taken downstream.
// Depends on ma10_pkg for the field widths and the default window length.
`timescale 1ns / 1ps

module moving_average_x10_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  input  logic                          sample_ready_i,
  input  logic [ma10_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          avg_valid_i,
  input  logic                          avg_ready_i,
  input  logic [ma10_pkg::AVG_W-1:0]    average_tenths_i,
  output int                            mismatch_count_o,
  output int                            pending_o
);
  import ma10_pkg::*;

  localparam int unsigned WINDOW = WINDOW_DEF;

  // Own copy of the window: ring of samples, fill level, next slot and sum.
  logic [SAMPLE_W-1:0] window_ring [WINDOW];
  int unsigned         held_samples;
  int unsigned         next_slot;
  int unsigned         window_sum;

  // Averages still owed by the block, oldest first.
  logic [AVG_W-1:0]    expected_averages [$];
  logic [AVG_W-1:0]    owed_average;

  // Adds one sample to the window and returns the average in tenths.
  function automatic logic [AVG_W-1:0] predict_average(input logic [SAMPLE_W-1:0] sample);
    int unsigned tenths;
    if (held_samples == WINDOW) begin
      // The slot about to be overwritten holds the oldest sample.
      window_sum   = window_sum - window_ring[next_slot];
      held_samples = WINDOW - 1;
    end
    held_samples           = held_samples + 1;
    window_ring[next_slot] = sample;
    window_sum             = window_sum + sample;
    next_slot              = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
    tenths                 = (window_sum * 10) / held_samples;
    return tenths[AVG_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count_o = mismatch_count_o + 1;
    if (mismatch_count_o <= 10) begin
      $display("%0t: %s: expected average_tenths %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_samples     = 0;
      next_slot        = 0;
      window_sum       = 0;
      expected_averages.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // Results are checked before new requests are predicted, so a result
      // that overtakes its own request is caught.
      if (avg_valid_i && avg_ready_i) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("result without request", -1, int'(average_tenths_i));
        end else begin
          owed_average = expected_averages.pop_front();
          if (average_tenths_i !== owed_average) begin
            report_mismatch("wrong average", int'(owed_average), int'(average_tenths_i));
          end
        end
      end
      if (sample_valid_i && sample_ready_i) begin
        expected_averages.push_back(predict_average(sample_i));
      end
      pending_o = expected_averages.size();
    end
  end

endmodule

### test/moving_average_x10_tb.sv
// Top of the moving average testbench: clock, reset, sample stimulus and
// output back-pressure, with the verdict taken from the checker.
// Depends on ma10_pkg, ma10_if, moving_average_x10 and its checker.
`timescale 1ns / 1ps

module moving_average_x10_tb;
  import ma10_pkg::*;

  logic clk_i;
  logic rst_ni;

  // Percentage of cycles in which the receiver holds ready low.
  int   recv_idle_pct;
  int   mismatch_count;
  int   pending_averages;

  ma10_sample_if in_if ();
  ma10_avg_if    out_if ();

  moving_average_x10 i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  moving_average_x10_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (in_if.valid),
    .sample_ready_i   (in_if.ready),
    .sample_i         (in_if.sample),
    .avg_valid_i      (out_if.valid),
    .avg_ready_i      (out_if.ready),
    .average_tenths_i (out_if.average_tenths),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_averages)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on the run. The slowest correct run, with the heaviest idling
  // on both sides and the divider working one bit a step on each request, is
  // well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // The receiver decides afresh at every rising edge whether it will take a
  // result, so stalls land on every phase of the divider's work.
  initial begin
    out_if.ready  <= 1'b0;
    recv_idle_pct  = 0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one sample after a random number of idle cycles and returns at
  // the rising edge at which the block takes it. Ready is looked at on the
  // falling edge, where it is stable, so the acceptance test is free of
  // races with the block's own updates. Valid stays high when the next
  // request follows without a gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid  <= 1'b0;
      in_if.sample <= SAMPLE_W'($urandom_range(4095));
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= sample;
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int send_idle_pct;
    logic [SAMPLE_W-1:0] sample;

    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A run of full-scale samples gives the largest average
    // while the window fills, then keeps it as the window becomes full and
    // the oldest sample starts being displaced. A zero then pulls one
    // full-scale sample out of the sum, and alternating bit patterns and a
    // one follow on the full window.
    repeat (21) send_sample(12'hFFF, 0);
    send_sample(12'h000, 0);
    send_sample(12'hAAA, 0);
    send_sample(12'h555, 0);
    send_sample(12'h001, 0);

    // Random part in three phases: first the sender idles lightly and the
    // receiver heavily, then the other way round, then neither idles.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        // Full-range samples in four cases of ten, the rest near both ends of the range
        // so that the sum sits at its extremes as the window turns over.
        case ($urandom_range(9))
          0, 1:    sample = $urandom_range(1) ? 12'hFFF : 12'h000;
          2, 3:    sample = SAMPLE_W'($urandom_range(15));
          4, 5:    sample = SAMPLE_W'($urandom_range(4095, 4080));
          default: sample = SAMPLE_W'($urandom_range(4095));
        endcase
        send_sample(sample, send_idle_pct);
      end
    end
    in_if.valid <= 1'b0;

    // Drain: wait for every owed average, then give the block a further
    // stretch longer than its latency to show any stray result.
    while (pending_averages != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (mismatch_count == 0 && pending_averages == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/ma10_pkg.sv
rtl/ma10_if.sv
rtl/ma10_ram.sv
rtl/ma10_div.sv
rtl/moving_average_x10.sv
test/moving_average_x10_checker.sv
test/moving_average_x10_tb.sv
